// ----- rtl/core/rgb_sharpen_3x3_top_defines.svh -----
// Assertion macros shared by the sharpen filter RTL.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef RGB_SHARPEN_3X3_TOP_DEFINES_SVH
`define RGB_SHARPEN_3X3_TOP_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define RGBS_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Same-cycle implication.
`define RGBS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rgbs_pkg.sv -----
// Types and constants of the 3x3 RGB sharpen filter.
// No dependencies; used by every other RTL file of the block.
package rgbs_pkg;

  localparam int MAX_LINE_DEF = 2048;
  localparam int MAX_HEIGHT   = 4096;
  localparam int DEF_WIDTH    = 640;
  localparam int DEF_HEIGHT   = 480;
  localparam int MIN_DIM      = 3;
  localparam int ROW_W        = 13;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  // kernel: 50 at the centre, -3 on the four cross neighbors, then /38
  localparam int KERN_CENTER = 50;
  localparam int KERN_NEIGH  = 3;
  localparam int DIVISOR     = 38;
  localparam int SAT_LIMIT   = DIVISOR * 256;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP       = (2**RECIP_SHIFT + DIVISOR - 1) / DIVISOR;

  typedef logic [23:0] pix_t;  // {blue, green, red}

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       drain;
  } in_pix_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       end_of_line;
    logic       end_of_frame;
  } out_pix_t;

  // where a result pixel comes from
  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_FILTER,
    SRC_CENTER,
    SRC_LASTUP,
    SRC_TAIL
  } src_t;

  typedef struct packed {
    logic load_sum;
    logic load_quo;
  } shp_ctl_t;

endpackage

// ----- rtl/core/rgbs_stream_if.sv -----
// Valid/ready stream interfaces for the pixel input and result channels.
// Depends on rgbs_pkg for the payload types.
interface rgbs_in_if;
  import rgbs_pkg::*;
  logic    valid;
  logic    ready;
  in_pix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rgbs_out_if;
  import rgbs_pkg::*;
  logic     valid;
  logic     ready;
  out_pix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/rgb_sharpen_3x3_top.sv -----
// Usage:
// Pixels enter on in_ch in raster order, one per transaction; results leave
// on out_ch as valid/ready transactions. Interior pixels get the cross-shaped
// sharpening kernel per channel, border pixels pass through unchanged.
// A result trails its pixel by one line plus one pixel of input; after the
// last pixel of a frame, send width+1 transactions with drain=1 to flush the
// last line. Drain transactions during the frame are dropped.
// Throughput is one transaction per cycle while out_ch does not stall. The
// pipeline stages are the line-store read, the window, the kernel sum, the
// reciprocal multiply, and the clamp into the output register.
// When out_ch stalls, the output register holds its result and the stages
// behind it keep filling; in_ch.ready falls once all stages hold a result.
// Reset sets width 640 and height 480 and starts a new frame; the line
// stores are not cleared and need no clearing pass. A cfg write to width
// (index 0) or height (index 1) also restarts the frame; write only while
// the block is idle.
// Depends on rgbs_pkg, rgbs_stream_if, rgbs_line_ram and rgbs_sharpen.
`include "rgb_sharpen_3x3_top_defines.svh"

module rgb_sharpen_3x3_top import rgbs_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  rgbs_in_if.sink               in_ch,
  rgbs_out_if.source            out_ch
);

  localparam int AW = $clog2(MAX_LINE);
  localparam int CW = $clog2(MAX_LINE + 1);

  function automatic logic [CW-1:0] eff_width(input logic [11:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x < 32'(MIN_DIM)) x = 32'(MIN_DIM);
    if (x > 32'(MAX_LINE)) x = 32'(MAX_LINE);
    return x[CW-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] eff_height(input logic [12:0] v);
    logic [ROW_W-1:0] x;
    x = v;
    if (x < ROW_W'(MIN_DIM)) x = ROW_W'(MIN_DIM);
    if (x > ROW_W'(MAX_HEIGHT)) x = ROW_W'(MAX_HEIGHT);
    return x;
  endfunction

  // frame geometry and position
  logic [CW-1:0]    w_r;
  logic [ROW_W-1:0] h_r;
  logic [CW-1:0]    col_r, col_nxt, col_m1;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             tail, last_col, cfg_hit;

  // handshake and stage moves
  logic     accept, s1_free, s2_free, s3_free, s4_free, out_free;
  logic     mv1, mv2, mv3, mv4;
  in_pix_t  in_d;

  // accept-stage decode
  logic          push, shift, cap;
  src_t          kind;
  logic          eol, eof;
  logic [AW-1:0] addr;

  // stage 1: line-store read in flight
  logic          v1_r;
  src_t          kind1_r;
  logic          shift1_r, cap1_r, eol1_r, eof1_r;
  logic [AW-1:0] addr1_r;
  pix_t          px1_r;
  pix_t          rd_u, rd_m;

  // window: middle row three wide, upper/lower rows keep the centre column
  pix_t m0_r, m1_r, m2_r, u1_r, u2_r, d1_r, d2_r;
  pix_t last_up_r;

  // stages 2..4
  logic v2_r, filt2_r, eol2_r, eof2_r;
  pix_t pass2_r, pass2_nxt;
  logic v3_r, filt3_r, eol3_r, eof3_r;
  pix_t pass3_r;
  logic v4_r, filt4_r, eol4_r, eof4_r;
  pix_t pass4_r;
  pix_t filt_pix;
  pix_t res_pix;

  logic     out_valid_r;
  out_pix_t out_r;
  shp_ctl_t shp_ctl;

  assign in_d = in_ch.data;

  // stall chain, output side first
  assign out_free = !out_valid_r || out_ch.ready;
  assign mv4      = v4_r && out_free;
  assign s4_free  = !v4_r || mv4;
  assign mv3      = v3_r && s4_free;
  assign s3_free  = !v3_r || mv3;
  assign mv2      = v2_r && s3_free;
  assign s2_free  = !v2_r || mv2;
  // the window belongs to stage 2, so stage 1 waits for it even when idle
  assign mv1      = v1_r && s2_free;
  assign s1_free  = !v1_r || mv1;

  assign in_ch.ready = s1_free;
  assign accept      = in_ch.valid && s1_free;

  assign cfg_hit  = cfg_we && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT);
  assign tail     = (row_r == h_r);
  assign last_col = (col_r == w_r - CW'(1));
  assign col_m1   = col_r - CW'(1);

  always_comb begin
    push    = 1'b0;
    shift   = 1'b0;
    cap     = 1'b0;
    kind    = SRC_NONE;
    eol     = 1'b0;
    eof     = 1'b0;
    addr    = col_r[AW-1:0];
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (tail) begin
        // flush: right edge of the second-last row, then the last row
        push = 1'b1;
        if (col_r == '0) begin
          kind = SRC_LASTUP;
          eol  = 1'b1;
        end else begin
          kind = SRC_TAIL;
          addr = col_m1[AW-1:0];
          eol  = (col_r == w_r);
          eof  = (col_r == w_r);
        end
        if (col_r == w_r) begin
          col_nxt = '0;
          row_nxt = '0;
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end else if (!in_d.drain) begin
        push  = 1'b1;
        shift = 1'b1;
        cap   = last_col;
        if (row_r >= ROW_W'(2) && col_r == '0) begin
          kind = SRC_LASTUP;
          eol  = 1'b1;
        end else if (row_r != '0 && col_r != '0) begin
          kind = (row_r == ROW_W'(1) || col_r == CW'(1)) ? SRC_CENTER : SRC_FILTER;
        end
        if (last_col) begin
          col_nxt = '0;
          row_nxt = row_r + ROW_W'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

  // geometry, position and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= eff_width(12'(DEF_WIDTH));
      h_r         <= eff_height(13'(DEF_HEIGHT));
      col_r       <= '0;
      row_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_hit) begin
        unique case (cfg_idx)
          REG_WIDTH:  w_r <= eff_width(cfg_wdata[11:0]);
          REG_HEIGHT: h_r <= eff_height(cfg_wdata[12:0]);
          default: ;
        endcase
        col_r <= '0;
        row_r <= '0;
      end else begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (s1_free) v1_r <= push;
      if (s2_free) v2_r <= mv1 && (kind1_r != SRC_NONE);
      if (s3_free) v3_r <= mv2;
      if (s4_free) v4_r <= mv3;
      if (out_free) out_valid_r <= mv4;
    end
  end

  rgbs_line_ram #(.DEPTH(MAX_LINE)) u_upper (
    .clk     (clk),
    .rd_en   (push),
    .rd_addr (addr),
    .rd_data (rd_u),
    .wr_en   (mv1 && shift1_r),
    .wr_addr (addr1_r),
    .wr_data (rd_m)
  );

  rgbs_line_ram #(.DEPTH(MAX_LINE)) u_middle (
    .clk     (clk),
    .rd_en   (push),
    .rd_addr (addr),
    .rd_data (rd_m),
    .wr_en   (mv1 && shift1_r),
    .wr_addr (addr1_r),
    .wr_data (px1_r)
  );

  always_comb begin
    case (kind1_r)
      SRC_LASTUP: pass2_nxt = last_up_r;
      SRC_TAIL:   pass2_nxt = rd_m;
      default:    pass2_nxt = m2_r;  // centre after this shift
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (push) begin
      kind1_r  <= kind;
      shift1_r <= shift;
      cap1_r   <= cap;
      eol1_r   <= eol;
      eof1_r   <= eof;
      addr1_r  <= addr;
      px1_r    <= {in_d.blue_in, in_d.green_in, in_d.red_in};
    end
    if (mv1 && shift1_r) begin
      m0_r <= m1_r;
      m1_r <= m2_r;
      m2_r <= rd_m;
      u1_r <= u2_r;
      u2_r <= rd_u;
      d1_r <= d2_r;
      d2_r <= px1_r;
    end
    // right-edge pixel of the row above, emitted at the next row start
    if (mv1 && cap1_r) begin
      last_up_r <= rd_m;
    end
    if (mv1) begin
      filt2_r <= (kind1_r == SRC_FILTER);
      pass2_r <= pass2_nxt;
      eol2_r  <= eol1_r;
      eof2_r  <= eof1_r;
    end
    if (mv2) begin
      filt3_r <= filt2_r;
      pass3_r <= pass2_r;
      eol3_r  <= eol2_r;
      eof3_r  <= eof2_r;
    end
    if (mv3) begin
      filt4_r <= filt3_r;
      pass4_r <= pass3_r;
      eol4_r  <= eol3_r;
      eof4_r  <= eof3_r;
    end
    if (mv4) begin
      out_r.red_out      <= res_pix[7:0];
      out_r.green_out    <= res_pix[15:8];
      out_r.blue_out     <= res_pix[23:16];
      out_r.end_of_line  <= eol4_r;
      out_r.end_of_frame <= eof4_r;
    end
  end

  assign shp_ctl.load_sum = mv2;
  assign shp_ctl.load_quo = mv3;

  rgbs_sharpen u_sharpen (
    .clk    (clk),
    .ctl    (shp_ctl),
    .centre (m1_r),
    .left   (m0_r),
    .right  (m2_r),
    .up     (u1_r),
    .down   (d1_r),
    .result (filt_pix)
  );

  assign res_pix = filt4_r ? filt_pix : pass4_r;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  `RGBS_ASSERT_HOLDS(a_row_bound, row_r <= h_r, "row count past frame height")
  `RGBS_ASSERT_IMPLIES(a_col_frame, row_r != h_r, col_r < w_r, "column past line width")
  `RGBS_ASSERT_IMPLIES(a_col_tail, row_r == h_r, col_r <= w_r, "flush column past width")
  `RGBS_ASSERT_IMPLIES(a_eof_eol, out_valid_r && out_r.end_of_frame, out_r.end_of_line, "frame end without line end")

endmodule

// ----- rtl/core/rgbs_line_ram.sv -----
// One line store: simple dual-port RAM, one write and one registered read.
// Depends on rgbs_pkg for the pixel type.
module rgbs_line_ram import rgbs_pkg::*; #(
  parameter int DEPTH = MAX_LINE_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output pix_t          rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pix_t          wr_data
);

  pix_t mem [DEPTH];
  pix_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/rgbs_sharpen.sv -----
// Sharpen arithmetic for the three channels: kernel sum, then /38 by
// reciprocal multiply, then clamp to 0..255. Depends on rgbs_pkg.
module rgbs_sharpen import rgbs_pkg::*; (
  input  logic     clk,
  input  shp_ctl_t ctl,
  input  pix_t     centre,
  input  pix_t     left,
  input  pix_t     right,
  input  pix_t     up,
  input  pix_t     down,
  output pix_t     result
);

  logic [7:0] chan_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_chan
    logic [9:0]  nsum;
    logic [13:0] cterm;
    logic [11:0] nterm;
    logic [14:0] s_nxt;
    logic [14:0] s_r;
    logic [28:0] prod;
    logic        zero_nxt;
    logic        sat_nxt;
    logic [7:0]  q_r;
    logic        zero_r;
    logic        sat_r;

    always_comb begin
      nsum  = 10'(up[8*k +: 8]) + 10'(down[8*k +: 8])
            + 10'(left[8*k +: 8]) + 10'(right[8*k +: 8]);
      cterm = 14'(KERN_CENTER) * 14'(centre[8*k +: 8]);
      nterm = 12'(KERN_NEIGH) * 12'(nsum);
      // two's complement, bit 14 is the sign
      s_nxt = 15'(cterm) - 15'(nterm);
    end

    always_ff @(posedge clk) begin
      if (ctl.load_sum) begin
        s_r <= s_nxt;
      end
    end

    // only meaningful for 0 < s < SAT_LIMIT, flags cover the rest
    always_comb begin
      prod     = 29'(s_r[13:0]) * 29'(RECIP);
      zero_nxt = s_r[14] || (s_r == '0);
      sat_nxt  = !s_r[14] && (s_r[13:0] >= 14'(SAT_LIMIT));
    end

    always_ff @(posedge clk) begin
      if (ctl.load_quo) begin
        q_r    <= prod[RECIP_SHIFT +: 8];
        zero_r <= zero_nxt;
        sat_r  <= sat_nxt;
      end
    end

    assign chan_q[k] = zero_r ? 8'd0 : (sat_r ? 8'hFF : q_r);
  end

  assign result = {chan_q[2], chan_q[1], chan_q[0]};

endmodule

// ----- test/rgb_sharpen_3x3_top_tb.sv -----
// Testbench for rgb_sharpen_3x3_top: streams RGB frames of many sizes and checks
// every result pixel against a scoreboard that models the 3x3 sharpen filter.
// Depends on rgbs_pkg, rgbs_stream_if and the block's RTL.
module rgb_sharpen_3x3_top_tb import rgbs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 600_000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int SETTLE_CYCLES = 12;  // pipeline is 5 deep
  localparam int DRAIN_CYCLES  = 20;
  localparam int END_GUARD     = 5000;
  localparam int MAX_PRINTS    = 40;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Frame model: line stores, window and counters, plus the results still owed.
  class sharpen_tracker;
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    pix_t        upper_row [MAX_LINE_DEF];
    pix_t        middle_row [MAX_LINE_DEF];
    pix_t        win [3][3];
    int unsigned col, row, emitted;
    out_pix_t    owed [$];
    int          errors;
    int          checked;

    function new();
      width_reg = 12'(DEF_WIDTH);
      height_reg = 13'(DEF_HEIGHT);
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        middle_row[i] = '0;
      end
      errors = 0;
      checked = 0;
      restart();
    endfunction

    function void restart();
      foreach (win[i, j]) win[i][j] = '0;
      col = 0;
      row = 0;
      emitted = 0;
    endfunction

    function int unsigned eff_w();
      int unsigned w;
      w = width_reg;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_LINE_DEF) w = MAX_LINE_DEF;
      return w;
    endfunction

    function int unsigned eff_h();
      int unsigned h;
      h = height_reg;
      if (h < MIN_DIM) h = MIN_DIM;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_WIDTH) begin
        width_reg = val[11:0];
        restart();
      end else if (idx == REG_HEIGHT) begin
        height_reg = val;
        restart();
      end
    endfunction

    function int chan(pix_t p, int sh);
      return int'(p[sh +: 8]);
    endfunction

    function logic [7:0] sharpen_chan(int sh);
      int s;
      s = KERN_CENTER * chan(win[1][1], sh)
        - KERN_NEIGH * (chan(win[0][1], sh) + chan(win[2][1], sh)
                        + chan(win[1][0], sh) + chan(win[1][2], sh));
      if (s <= 0) return 8'd0;
      s = s / DIVISOR;
      return (s > 255) ? 8'hFF : 8'(s);
    endfunction

    function pix_t filter_pixel();
      return {sharpen_chan(16), sharpen_chan(8), sharpen_chan(0)};
    endfunction

    function void owe_result(pix_t p, bit eol);
      out_pix_t o;
      int unsigned last;
      last = eff_w() * eff_h() - 1;
      o.red_out = p[7:0];
      o.green_out = p[15:8];
      o.blue_out = p[23:16];
      o.end_of_line = eol;
      o.end_of_frame = (emitted == last);
      owed.push_back(o);
      if (emitted == last) restart();
      else emitted++;
    endfunction

    // Called once per accepted input transaction.
    function void take_pixel(in_pix_t d);
      int unsigned w, h, c, r, oc;
      pix_t px, v;
      w = eff_w();
      h = eff_h();
      c = col;
      r = row;
      if (r >= h) begin
        // tail: last pixel of row h-2, then all of row h-1
        if (c == 0) begin
          owe_result(upper_row[w-1], 1'b1);
        end else begin
          oc = c - 1;
          if (oc >= w) oc = w - 1;
          owe_result(middle_row[oc], oc == w - 1);
        end
        if (emitted != 0) col = c + 1;
        return;
      end
      if (d.drain) return;
      if (c >= w) c = w - 1;
      px = {d.blue_in, d.green_in, d.red_in};
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = upper_row[c];
      win[1][2] = middle_row[c];
      win[2][2] = px;
      if (r >= 2 && c == 0) begin
        owe_result(upper_row[w-1], 1'b1);
      end else if (r >= 1 && c >= 1) begin
        v = (r == 1 || c == 1) ? win[1][1] : filter_pixel();
        owe_result(v, 1'b0);
      end
      upper_row[c] = middle_row[c];
      middle_row[c] = px;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      col = c;
      row = r;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("[sharpen] %s", msg);
    endtask

    task check_field(string name, int got, int want);
      if (got != want)
        report($sformatf("result %0d %s: got %0d, want %0d", checked, name, got, want));
    endtask

    task match_result(out_pix_t got);
      out_pix_t want;
      if (owed.size() == 0) begin
        report($sformatf("result %0d arrived with none owed: %h", checked, got));
        checked++;
        return;
      end
      want = owed.pop_front();
      check_field("red_out", got.red_out, want.red_out);
      check_field("green_out", got.green_out, want.green_out);
      check_field("blue_out", got.blue_out, want.blue_out);
      check_field("end_of_line", got.end_of_line, want.end_of_line);
      check_field("end_of_frame", got.end_of_frame, want.end_of_frame);
      checked++;
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  rgbs_in_if             in_ch ();
  rgbs_out_if            out_ch ();

  sharpen_tracker tracker = new();
  int          in_gap_max = 13;
  int          out_stall_max = 13;
  int          items_sent = 0;
  int unsigned cycle_count = 0;

  rgb_sharpen_3x3_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rgb_sharpen_3x3_top: mismatch");
      $finish;
    end
  end

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_pix_t random_pixel();
    in_pix_t d;
    d.red_in = pick_level();
    d.green_in = pick_level();
    d.blue_in = pick_level();
    d.drain = 1'b0;
    return d;
  endfunction

  function automatic int pick_pace();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      default: return 13;
    endcase
  endfunction

  // One input transaction; valid stays up across back-to-back items.
  task automatic send(in_pix_t d);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= d;
    do @(posedge clk); while (!in_ch.ready);
    tracker.take_pixel(d);
  endtask

  task automatic idle_in();
    in_ch.valid <= 1'b0;
  endtask

  task automatic hold_until_done();
    idle_in();
    do @(posedge clk); while (tracker.owed.size() != 0);
  endtask

  task automatic wait_quiet();
    hold_until_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Back-to-back register writes; write enable stays high between them.
  task automatic set_size(logic [12:0] width_val, logic [12:0] height_val,
                          bit do_w, bit do_h, bit junk);
    if (do_w) begin
      cfg_we <= 1'b1;
      cfg_idx <= REG_WIDTH;
      cfg_wdata <= width_val;
      tracker.write_reg(REG_WIDTH, width_val);
      @(posedge clk);
    end
    if (do_h) begin
      cfg_we <= 1'b1;
      cfg_idx <= REG_HEIGHT;
      cfg_wdata <= height_val;
      tracker.write_reg(REG_HEIGHT, height_val);
      @(posedge clk);
    end
    if (junk) begin
      // unmapped index: no effect, no frame restart
      cfg_we <= 1'b1;
      cfg_idx <= ($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B;
      cfg_wdata <= 13'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_body(int count, int noise_pct);
    in_pix_t d;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        d = random_pixel();
        d.drain = 1'b1;
        send(d);
      end
      if ($urandom_range(0, 299) == 0) hold_until_done();
      send(random_pixel());
      items_sent++;
    end
  endtask

  task automatic send_tail(int count);
    in_pix_t d;
    for (int i = 0; i < count; i++) begin
      d = random_pixel();
      d.drain = ($urandom_range(0, 4) != 0);
      send(d);
      items_sent++;
    end
  endtask

  // Complete frames, then optionally one frame cut off after cut_items transactions.
  task automatic stream_frames(int frames, int cut_items);
    int w, h, n_body;
    in_pix_t d;
    w = tracker.eff_w();
    h = tracker.eff_h();
    n_body = w * h;
    for (int f = 0; f < frames; f++) begin
      send_body(n_body, 5);
      send_tail(w + 1);
      if ($urandom_range(0, 4) == 0) begin
        // drains after frame end are dropped
        for (int i = $urandom_range(1, 3); i > 0; i--) begin
          d = random_pixel();
          d.drain = 1'b1;
          send(d);
        end
      end
    end
    if (cut_items > 0) begin
      send_body((cut_items < n_body) ? cut_items : n_body, 5);
      if (cut_items > n_body) send_tail(cut_items - n_body);
    end
  endtask

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      tracker.match_result(out_ch.data);
    end
  end

  initial begin : stimulus
    in_pix_t     d;
    logic [12:0] w_raw, h_raw;
    logic [7:0]  red_pat [16];
    int          sel, guard, n_body;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_WIDTH;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // 4x4 frame: red hits the clamp at both ends, green stays in range
    red_pat = '{8'h00, 8'h00, 8'hFF, 8'h00,
                8'h00, 8'hFF, 8'h00, 8'hFF,
                8'h00, 8'h00, 8'hFF, 8'h00,
                8'h77, 8'h00, 8'hFF, 8'h01};
    set_size(13'd4, 13'd4, 1'b1, 1'b1, 1'b1);
    for (int i = 0; i < 16; i++) begin
      if (i == 8) begin
        d = random_pixel();
        d.drain = 1'b1;  // mid-frame drain, dropped
        send(d);
        hold_until_done();
      end
      d.red_in = red_pat[i];
      d.green_in = 8'(30 + 15 * i);
      d.blue_in = (i % 3 == 0) ? 8'hFF : 8'(17 * i);
      d.drain = 1'b0;
      send(d);
    end
    for (int i = 0; i < 5; i++) begin
      d = random_pixel();
      d.drain = (i != 2);  // a real pixel in the tail flushes like a drain
      send(d);
    end

    // size extremes: clamped-up 3x3, widest line, tallest frame
    wait_quiet();
    set_size(13'd0, 13'd0, 1'b1, 1'b1, 1'b0);
    stream_frames(1, 0);
    wait_quiet();
    in_gap_max = 3;
    out_stall_max = 3;
    set_size(13'h1FFF, 13'd3, 1'b1, 1'b1, 1'b0);
    stream_frames(0, MAX_LINE_DEF + 24);
    wait_quiet();
    in_gap_max = 13;
    out_stall_max = 13;
    set_size(13'd3, 13'h1FFF, 1'b1, 1'b1, 1'b0);
    stream_frames(0, 30);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      w_raw = 13'($urandom_range(3, 12));
      h_raw = 13'($urandom_range(3, 8));
      case ($urandom_range(0, 19))
        0: w_raw = 13'($urandom_range(0, 2));
        1: h_raw = 13'($urandom_range(0, 2));
        2: w_raw = 13'($urandom_range(13, 40));
        default: ;
      endcase
      w_raw[12] = 1'($urandom);  // outside the width register
      wait_quiet();
      in_gap_max = pick_pace();
      out_stall_max = pick_pace();
      sel = $urandom_range(0, 3);
      set_size(w_raw, h_raw, sel != 3, sel != 2, $urandom_range(0, 3) == 0);
      n_body = tracker.eff_w() * tracker.eff_h();
      if ($urandom_range(0, 5) == 0)
        stream_frames(0, $urandom_range(1, n_body + tracker.eff_w()));
      else
        stream_frames($urandom_range(1, 2), 0);
    end

    idle_in();
    guard = 0;
    while (tracker.owed.size() != 0 && guard < END_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.owed.size() != 0)
      tracker.report($sformatf("%0d owed results never came", tracker.owed.size()));
    if (tracker.errors == 0)
      $display("rgb_sharpen_3x3_top: match");
    else
      $display("rgb_sharpen_3x3_top: mismatch");
    $finish;
  end

endmodule
